/* hw/rtl/gsse_pkg.sv */
// ----------------------------------------------------------------------------
// gsse_pkg: shared types and constants for the GF(2^m) share evaluator
// Field widths, register codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package gsse_pkg;

	localparam int FIELD_BITS_DEF = 64;
	localparam int MAX_COEFFS_DEF = 16;

	localparam int COEF_W     = 64;
	localparam int PARTY_W    = 32;
	localparam int SLOT_W     = 4;
	localparam int THR_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [THR_W-1:0]  THR_RESET = 5'd2;
	localparam logic [COEF_W-1:0] MOD_RESET = 64'd27;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD     = 2'd0,
		REG_FIELD_MODULUS = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_BUILD,
		ST_IDLE,
		ST_FETCH,
		ST_MAC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic init_table;
		logic shift_table;
		logic accept;
		logic fetch;
		logic mac;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic mod_wr;
		logic eval;
		logic cnt_zero;
		logic last;
	} dp_status_t;

	// Number of reduction constants x^(m+i) mod P needed so that both a full
	// product (2m-1 bits) and a raw 64-bit coefficient can be folded back.
	function automatic int pow_count(input int fb);
		int pw;
		pw = (2 * fb - 1 > COEF_W) ? 2 * fb - 1 : COEF_W;
		return pw - fb;
	endfunction

endpackage

/* hw/rtl/gsse_if.sv */
// ----------------------------------------------------------------------------
// gsse_if: channel interfaces of the share evaluator
// Input item channel, share result channel and register write channel.
// ----------------------------------------------------------------------------
interface gsse_in_if import gsse_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [SLOT_W-1:0]   coef_index;
	logic [COEF_W-1:0]   coef_value;
	logic [PARTY_W-1:0]  party_index;

	modport source (output valid, action, coef_index, coef_value, party_index, input ready);
	modport sink   (input valid, action, coef_index, coef_value, party_index, output ready);
endinterface

interface gsse_out_if import gsse_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COEF_W-1:0]   share;
	logic [PARTY_W-1:0]  share_party;

	modport source (output valid, share, share_party, input ready);
	modport sink   (input valid, share, share_party, output ready);
endinterface

interface gsse_cfg_if import gsse_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/gf2n_shamir_share_eval_top.sv */
// ----------------------------------------------------------------------------
// gf2n_shamir_share_eval_top: Shamir share evaluation over GF(2^FIELD_BITS)
// Loads polynomial coefficients and evaluates shares at party points.
// ----------------------------------------------------------------------------
// Channels: item (sink) carries write items (action 0: coef_value into slot
// coef_index) and evaluate items (action 1: share for party_index+1).
// result (source) carries one share and its party per evaluate item; a write
// item gives no result. cfg (sink, always ready) writes threshold (index 0)
// and field_modulus (index 1); write it only while the block is idle.
// Flow: a write item is stored and the block stays idle, ready for another
// item. An evaluate item with k = min(threshold, MAX_COEFFS) coefficients
// goes through a memory read, k Horner steps of the single multiply-reduce
// unit and the output load before its result is valid; no new item is taken
// until that load. With k = 0 the Horner steps are skipped; the share is zero.
// Reset, and every field_modulus write, starts a sweep that builds the
// pow_count(FIELD_BITS) constants of the reduction table; no item is taken
// during it. The coefficient store is not cleared by reset.
// A stalled result waits in the output register; one more item can be taken
// and worked on, and its result then holds until the register frees up.
// ----------------------------------------------------------------------------
module gf2n_shamir_share_eval_top import gsse_pkg::*; #(
	parameter int FIELD_BITS = FIELD_BITS_DEF,
	parameter int MAX_COEFFS = MAX_COEFFS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gsse_in_if.sink    item,
	gsse_out_if.source result,
	gsse_cfg_if.sink   cfg
);

	ctl_cmd_t   cmd;
	dp_status_t st;

	assign cfg.ready = 1'b1;

	gsse_ctrl #(
		.FIELD_BITS (FIELD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.cmd       (cmd)
	);

	gsse_datapath #(
		.FIELD_BITS (FIELD_BITS),
		.MAX_COEFFS (MAX_COEFFS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.action      (item.action),
		.coef_index  (item.coef_index),
		.coef_value  (item.coef_value),
		.party_index (item.party_index),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.share       (result.share),
		.share_party (result.share_party)
	);

endmodule

/* hw/rtl/gsse_datapath.sv */
// ----------------------------------------------------------------------------
// gsse_datapath: registers, coefficient store and field arithmetic
// Holds the configuration, the table of reduction constants, the coefficient
// memory, and one carry-less multiply with table-driven reduction per cycle.
// ----------------------------------------------------------------------------
module gsse_datapath import gsse_pkg::*; #(
	parameter int FIELD_BITS = FIELD_BITS_DEF,
	parameter int MAX_COEFFS = MAX_COEFFS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_status_t            st,
	input  logic                  action,
	input  logic [SLOT_W-1:0]     coef_index,
	input  logic [COEF_W-1:0]     coef_value,
	input  logic [PARTY_W-1:0]    party_index,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [COEF_W-1:0]     share,
	output logic [PARTY_W-1:0]    share_party
);

	localparam int NPOW = pow_count(FIELD_BITS);
	localparam int PW   = FIELD_BITS + NPOW;
	localparam int AW   = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
	localparam int CW   = $clog2(MAX_COEFFS + 1);

	logic [THR_W-1:0]      thr_q;
	logic [COEF_W-1:0]     mod_q;
	logic [FIELD_BITS-1:0] mod_m;
	logic [FIELD_BITS-1:0] cur_q;
	logic [FIELD_BITS-1:0] cur_nxt;
	logic [FIELD_BITS-1:0] pow_q [NPOW];
	logic [COEF_W-1:0]     mem [MAX_COEFFS];
	logic [COEF_W-1:0]     rd_q;
	logic [FIELD_BITS-1:0] pt_q;
	logic [FIELD_BITS-1:0] acc_q;
	logic [PARTY_W-1:0]    party_q;
	logic [COEF_W-1:0]     share_q;
	logic [PARTY_W-1:0]    share_party_q;
	logic [AW-1:0]         idx_q;
	logic [CW-1:0]         left_q;
	logic [CW-1:0]         count;
	logic                  slot_ok;
	logic [PARTY_W-1:0]    pt_sum;
	logic [PW-1:0]         pt_wide;
	logic [FIELD_BITS-1:0] pt_red;
	logic [PW-1:0]         prod;
	logic [PW-1:0]         hv;
	logic [FIELD_BITS-1:0] acc_nxt;

	assign mod_m = mod_q[FIELD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			mod_q <= MOD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_THRESHOLD) begin
				thr_q <= cfg_data[THR_W-1:0];
			end
			if (cfg_index == REG_FIELD_MODULUS) begin
				mod_q <= cfg_data;
			end
		end
	end

	// Effective number of coefficients, capped at the store depth.
	always_comb begin
		if (32'(thr_q) > MAX_COEFFS) begin
			count = CW'(MAX_COEFFS);
		end else begin
			count = CW'(thr_q);
		end
	end

	assign slot_ok = 32'(coef_index) < MAX_COEFFS;

	assign st.mod_wr   = cfg_we && (cfg_index == REG_FIELD_MODULUS);
	assign st.eval     = action == ACT_EVAL;
	assign st.cnt_zero = count == '0;
	assign st.last     = left_q == CW'(1);

	// Table sweep: walk x^m, x^(m+1), ... by repeated multiply by x.
	assign cur_nxt = {cur_q[FIELD_BITS-2:0], 1'b0} ^ (cur_q[FIELD_BITS-1] ? mod_m : '0);

	always_ff @(posedge clk) begin
		if (cmd.init_table) begin
			cur_q <= mod_m;
		end else if (cmd.shift_table) begin
			cur_q <= cur_nxt;
			pow_q[NPOW-1] <= cur_q;
			for (int k = 0; k < NPOW - 1; k++) begin
				pow_q[k] <= pow_q[k+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && action == ACT_WRITE && slot_ok) begin
			mem[AW'(coef_index)] <= coef_value;
		end
		rd_q <= mem[idx_q];
	end

	// Evaluation point: party_index + 1 in 32 bits, folded into the field.
	assign pt_sum  = party_index + PARTY_W'(1);
	assign pt_wide = PW'(pt_sum);

	always_comb begin
		pt_red = pt_wide[FIELD_BITS-1:0];
		for (int i = 0; i < NPOW; i++) begin
			if (pt_wide[FIELD_BITS+i]) begin
				pt_red = pt_red ^ pow_q[i];
			end
		end
	end

	// Horner step: acc*x_pt + c_j, reduced once since reduction is linear.
	always_comb begin
		prod = '0;
		for (int i = 0; i < FIELD_BITS; i++) begin
			if (pt_q[i]) begin
				prod = prod ^ (PW'(acc_q) << i);
			end
		end
	end

	assign hv = prod ^ PW'(rd_q);

	always_comb begin
		acc_nxt = hv[FIELD_BITS-1:0];
		for (int i = 0; i < NPOW; i++) begin
			if (hv[FIELD_BITS+i]) begin
				acc_nxt = acc_nxt ^ pow_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pt_q    <= pt_red;
			party_q <= party_index;
			acc_q   <= '0;
		end else if (cmd.mac) begin
			acc_q <= acc_nxt;
		end
		if (cmd.emit) begin
			share_q       <= COEF_W'(acc_q);
			share_party_q <= party_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			left_q <= '0;
		end else if (cmd.accept) begin
			idx_q  <= AW'(count - CW'(1));
			left_q <= count;
		end else begin
			if (cmd.fetch || cmd.mac) begin
				idx_q <= idx_q - AW'(1);
			end
			if (cmd.mac) begin
				left_q <= left_q - CW'(1);
			end
		end
	end

	assign share       = share_q;
	assign share_party = share_party_q;

endmodule

/* hw/rtl/gsse_ctrl.sv */
// ----------------------------------------------------------------------------
// gsse_ctrl: sequencer of the share evaluator
// Runs the reduction-table sweep, takes items, steps Horner over the
// coefficients and hands the result to the output register.
// ----------------------------------------------------------------------------
module gsse_ctrl import gsse_pkg::*; #(
	parameter int FIELD_BITS = FIELD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output ctl_cmd_t   cmd
);

	localparam int NPOW = pow_count(FIELD_BITS);
	localparam int BCW  = $clog2(NPOW);

	state_t         state_q, state_d;
	logic [BCW-1:0] bcnt_q, bcnt_d;
	logic           out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			bcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			bcnt_q      <= bcnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		bcnt_d      = bcnt_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			ST_INIT: begin
				cmd.init_table = 1'b1;
				bcnt_d         = '0;
				state_d        = ST_BUILD;
			end
			ST_BUILD: begin
				cmd.shift_table = 1'b1;
				bcnt_d          = bcnt_q + BCW'(1);
				if (bcnt_q == BCW'(NPOW - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// hold off items while the modulus changes
				in_ready = !st.mod_wr;
				if (in_valid && !st.mod_wr) begin
					cmd.accept = 1'b1;
					if (st.eval) begin
						state_d = st.cnt_zero ? ST_DONE : ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (st.last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
		// a new modulus invalidates the reduction table: rebuild it
		if (st.mod_wr) begin
			state_d = ST_INIT;
		end
	end

	assign out_valid = out_valid_q;

endmodule
